// ----- src/b85_pkg.sv -----
package b85_pkg;

  // field widths
  localparam int unsigned AddrW = 64;
  localparam int unsigned CharW = 7;
  localparam int unsigned RemW = 7;
  localparam int unsigned QuotW = 2 * AddrW;

  // division constants
  localparam int unsigned Radix = 85;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigitCntW = $clog2(NumDigits);
  localparam int unsigned BytesPerQuot = QuotW / 8;
  localparam int unsigned ByteCntW = $clog2(BytesPerQuot);

  localparam logic [DigitCntW-1:0] LastDigit = DigitCntW'(NumDigits - 1);
  localparam logic [ByteCntW-1:0] LastByte = ByteCntW'(BytesPerQuot - 1);

  // control from the sequencer to the divide unit
  typedef struct packed {
    logic load;
    logic step;
    logic last_byte;
  } div_ctrl_t;

  // status from the divide unit
  typedef struct packed {
    logic [RemW-1:0] rem_next;
    logic            quot_zero;
  } div_stat_t;

  // rfc 1924 alphabet: 0-9, A-Z, a-z, then the symbol set
  function automatic logic [CharW-1:0] digit_to_char(input logic [RemW-1:0] r);
    logic [CharW-1:0] c;
    c = 7'd48;
    if (r < 7'd10) begin
      c = 7'(r + 7'd48);
    end else if (r < 7'd36) begin
      c = 7'(r + 7'd55);
    end else if (r < 7'd62) begin
      c = 7'(r + 7'd61);
    end else begin
      case (r)
        7'd62: c = 7'd33;
        7'd63: c = 7'd35;
        7'd64: c = 7'd36;
        7'd65: c = 7'd37;
        7'd66: c = 7'd38;
        7'd67: c = 7'd40;
        7'd68: c = 7'd41;
        7'd69: c = 7'd42;
        7'd70: c = 7'd43;
        7'd71: c = 7'd45;
        7'd72: c = 7'd59;
        7'd73: c = 7'd60;
        7'd74: c = 7'd61;
        7'd75: c = 7'd62;
        7'd76: c = 7'd63;
        7'd77: c = 7'd64;
        7'd78: c = 7'd94;
        7'd79: c = 7'd95;
        7'd80: c = 7'd96;
        7'd81: c = 7'd123;
        7'd82: c = 7'd124;
        7'd83: c = 7'd125;
        7'd84: c = 7'd126;
        default: c = 7'd48;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- src/b85_if.sv -----
// address channel
interface b85_addr_if;
  logic                           valid;
  logic                           ready;
  logic [b85_pkg::AddrW-1:0]      addr_hi;
  logic [b85_pkg::AddrW-1:0]      addr_lo;

  modport source (output valid, output addr_hi, output addr_lo, input ready);
  modport sink (input valid, input addr_hi, input addr_lo, output ready);
endinterface

// digit channel
interface b85_digit_if;
  logic                           valid;
  logic                           ready;
  logic [b85_pkg::CharW-1:0]      digit_char;
  logic                           digit_last;

  modport source (output valid, output digit_char, output digit_last, input ready);
  modport sink (input valid, input digit_char, input digit_last, output ready);
endinterface

// ----- src/b85_div_unit.sv -----
module b85_div_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b85_pkg::div_ctrl_t        ctrl_i,
  input  logic [b85_pkg::AddrW-1:0] addr_hi_i,
  input  logic [b85_pkg::AddrW-1:0] addr_lo_i,
  output b85_pkg::div_stat_t        stat_o
);

  logic [b85_pkg::QuotW-1:0] quot_q, quot_d;
  logic [b85_pkg::RemW-1:0]  rem_q, rem_d;
  logic [b85_pkg::RemW-1:0]  rem_nx;
  logic [7:0]                qbyte;

  // restoring division of one byte by the radix, top bit first
  always_comb begin
    logic [7:0]               t;
    logic [b85_pkg::RemW-1:0] r;
    logic [7:0]               in_byte;
    r = rem_q;
    in_byte = quot_q[b85_pkg::QuotW-1 -: 8];
    qbyte = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, in_byte[7-i]};
      if (t >= 8'(b85_pkg::Radix)) begin
        t = 8'(t - 8'(b85_pkg::Radix));
        qbyte[7-i] = 1'b1;
      end
      r = t[b85_pkg::RemW-1:0];
    end
    rem_nx = r;
  end

  // quotient shifts left a byte per step, new quotient bytes enter at the bottom
  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      quot_d = {addr_hi_i, addr_lo_i};
      rem_d = '0;
    end else if (ctrl_i.step) begin
      quot_d = {quot_q[b85_pkg::QuotW-9:0], qbyte};
      rem_d = ctrl_i.last_byte ? '0 : rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q <= '0;
    end else begin
      quot_q <= quot_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.rem_next = rem_nx;
  assign stat_o.quot_zero = (quot_q == '0);

endmodule

// ----- src/base85_ipv6_encode.sv -----
// RFC 1924 base85 encoder for one IPv6 address. An address transaction carries
// the 128-bit value as two 64-bit halves; the block answers with 20 digit
// transactions, most significant digit first, each one ASCII character of the
// 85-symbol alphabet, with digit_last set on the twentieth. The address is
// divided by 85 twenty times on one shared byte-wide restoring divider that
// takes 8 quotient bits per cycle; the 20 digits then leave at up to one per
// cycle, as the sink takes them. The address channel is ready only while the
// block is idle; the last digit may still wait in the output register while
// the next address is accepted.
module base85_ipv6_encode (
  input  logic        clk_i,
  input  logic        rst_ni,
  b85_addr_if.sink    addr_i,
  b85_digit_if.source digit_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [b85_pkg::ByteCntW-1:0]      byte_cnt_q, byte_cnt_d;
  logic [b85_pkg::DigitCntW-1:0]     digit_cnt_q, digit_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [b85_pkg::CharW-1:0]         out_char_q;
  logic                              out_last_q;
  logic [b85_pkg::CharW-1:0]         store_q [b85_pkg::NumDigits];

  b85_pkg::div_ctrl_t div_ctrl;
  b85_pkg::div_stat_t div_stat;

  logic in_fire;
  logic digit_wr;
  logic out_load;

  assign addr_i.ready = (state_q == StIdle);
  assign in_fire = addr_i.valid && addr_i.ready;
  assign digit_wr = (state_q == StDiv) && (byte_cnt_q == b85_pkg::LastByte);
  assign out_load = (state_q == StEmit) && (!out_valid_q || digit_o.ready);

  assign div_ctrl.load = in_fire;
  assign div_ctrl.step = (state_q == StDiv);
  assign div_ctrl.last_byte = (byte_cnt_q == b85_pkg::LastByte);

  b85_div_unit u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .addr_hi_i (addr_i.addr_hi),
    .addr_lo_i (addr_i.addr_lo),
    .stat_o    (div_stat)
  );

  // sequencer: divide twenty times, then count the digits back out
  always_comb begin
    state_d = state_q;
    byte_cnt_d = byte_cnt_q;
    digit_cnt_d = digit_cnt_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StDiv;
          byte_cnt_d = '0;
          digit_cnt_d = '0;
        end
      end
      StDiv: begin
        byte_cnt_d = byte_cnt_q + 1'b1;
        if (digit_wr) begin
          if (digit_cnt_q == b85_pkg::LastDigit) begin
            state_d = StEmit;
          end else begin
            digit_cnt_d = digit_cnt_q + 1'b1;
          end
        end
      end
      StEmit: begin
        if (out_load) begin
          if (digit_cnt_q == '0) begin
            state_d = StIdle;
          end else begin
            digit_cnt_d = digit_cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (digit_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      byte_cnt_q <= '0;
      digit_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      byte_cnt_q <= byte_cnt_d;
      digit_cnt_q <= digit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk_i) begin
    if (digit_wr) begin
      store_q[digit_cnt_q] <= b85_pkg::digit_to_char(div_stat.rem_next);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= store_q[digit_cnt_q];
      out_last_q <= (digit_cnt_q == '0);
    end
  end

  assign digit_o.valid = out_valid_q;
  assign digit_o.digit_char = out_char_q;
  assign digit_o.digit_last = out_last_q;

  // an accepted address starts a fresh divide
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StDiv) && (byte_cnt_q == '0) && (digit_cnt_q == '0))
    else $error("divide did not start cleanly");

  // the twentieth remainder moves the block to emitting
  a_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_wr && (digit_cnt_q == b85_pkg::LastDigit) |=> (state_q == StEmit))
    else $error("missed end of dividing phase");

  // twenty divides by 85 always leave a zero quotient
  a_quot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> div_stat.quot_zero)
    else $error("quotient not zero after last digit");

  // the last digit is only loaded on the way out of emitting
  a_last_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (digit_cnt_q == '0) |=> (state_q == StIdle) && digit_o.digit_last)
    else $error("last digit flag out of step with sequencer");

endmodule
